### hw/rtl/time_to_haptic_pattern_encoder_defines.svh
// ----------------------------------------------------------------------------
// Haptic time encoder assertion macros
// Shared property forms for the checker of the haptic time encoder.
// ----------------------------------------------------------------------------
`ifndef TIME_TO_HAPTIC_PATTERN_ENCODER_DEFINES_SVH
`define TIME_TO_HAPTIC_PATTERN_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define THP_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define THP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/thp_pkg.sv
// ----------------------------------------------------------------------------
// Haptic time encoder package
// Segment codes, pattern word, timing registers and shared helpers.
// ----------------------------------------------------------------------------
package thp_pkg;

	localparam int MAX_SEGMENTS = 17;
	localparam int SEG_IDX_W    = 5;
	localparam int MS_W         = 16;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [MS_W-1:0] SHORT_PULSE_RST = 16'd50;
	localparam logic [MS_W-1:0] LONG_PULSE_RST  = 16'd200;
	localparam logic [MS_W-1:0] SHORT_GAP_RST   = 16'd400;
	localparam logic [MS_W-1:0] LONG_GAP_RST    = 16'd1000;

	typedef logic [MS_W-1:0]      ms_t;
	typedef logic [SEG_IDX_W-1:0] seg_idx_t;

	typedef enum logic [2:0] {
		SEG_EMPTY,
		SEG_SHORT_PULSE,
		SEG_LONG_PULSE,
		SEG_SHORT_GAP,
		SEG_LONG_GAP
	} seg_code_t;

	typedef enum logic [1:0] {
		REG_SHORT_PULSE,
		REG_LONG_PULSE,
		REG_SHORT_GAP,
		REG_LONG_GAP
	} reg_idx_t;

	// One whole pattern: a code per segment position and the segment count
	typedef struct packed {
		seg_code_t [MAX_SEGMENTS-1:0] code;
		seg_idx_t                     count;
	} pattern_t;

	typedef struct packed {
		ms_t short_pulse;
		ms_t long_pulse;
		ms_t short_gap;
		ms_t long_gap;
	} timing_t;

	function automatic ms_t seg_ms(input seg_code_t code, input timing_t tm);
		ms_t ms;
		case (code)
			SEG_SHORT_PULSE: ms = tm.short_pulse;
			SEG_LONG_PULSE:  ms = tm.long_pulse;
			SEG_SHORT_GAP:   ms = tm.short_gap;
			SEG_LONG_GAP:    ms = tm.long_gap;
			default:         ms = '0;
		endcase
		return ms;
	endfunction

endpackage

### hw/rtl/thp_front.sv
// ----------------------------------------------------------------------------
// Haptic time encoder front end
// Takes hour and minute, reduces them and registers the segment code list.
// ----------------------------------------------------------------------------
module thp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [4:0]        hour,
	input  logic [5:0]        minute,
	output logic              pat_valid,
	input  logic              pat_ready,
	output thp_pkg::pattern_t pat
);
	import thp_pkg::*;

	typedef struct packed {
		seg_code_t [7:0] code;
		logic [2:0]      len;
	} group_t;

	// Twelfths code of a value already reduced to 0..11
	function automatic group_t twelfths(input logic [3:0] v);
		group_t     g;
		logic [3:0] r6;
		logic [3:0] r3;
		seg_code_t  third;
		g  = '0;
		r6 = (v >= 4'd6) ? 4'(v - 4'd6) : v;
		r3 = (r6 >= 4'd3) ? 4'(r6 - 4'd3) : r6;
		case (r3)
			4'd0:    third = SEG_EMPTY;
			4'd1:    third = SEG_SHORT_PULSE;
			default: third = SEG_LONG_PULSE;
		endcase
		g.code[0] = (v < 4'd6) ? SEG_SHORT_PULSE : SEG_LONG_PULSE;
		g.code[1] = SEG_SHORT_GAP;
		if (r6 != 4'd0) begin
			g.code[2] = (r6 < 4'd3) ? SEG_SHORT_PULSE : SEG_LONG_PULSE;
			g.code[3] = SEG_SHORT_GAP;
			g.code[4] = third;
			g.code[5] = SEG_LONG_GAP;
			g.len     = 3'd6;
		end else begin
			g.code[2] = third;
			g.code[3] = SEG_LONG_GAP;
			g.len     = 3'd4;
		end
		return g;
	endfunction

	logic [4:0] hour_red;
	logic [3:0] hour_mod;
	logic [9:0] min_prod;
	logic [3:0] min_q;
	logic [3:0] min_grp;
	logic [5:0] min_rem;
	group_t     grp_h;
	group_t     grp_m;
	group_t     grp_d;
	seg_idx_t   off_m;
	seg_idx_t   off_d;
	seg_idx_t   rel;
	pattern_t   pat_next;

	pattern_t   pat_s1;
	logic       valid_s1;
	logic       in_acc;

	always_comb begin
		if (hour >= 5'd24) begin
			hour_red = 5'(hour - 5'd24);
		end else if (hour >= 5'd12) begin
			hour_red = 5'(hour - 5'd12);
		end else begin
			hour_red = hour;
		end
		hour_mod = hour_red[3:0];

		// minute / 5 as (minute * 13) >> 6, exact over 0..63
		min_prod = 10'(minute) * 10'd13;
		min_q    = min_prod[9:6];
		min_rem  = 6'(minute - 6'({2'b00, min_q} + {min_q, 2'b00}));
		min_grp  = (min_q == 4'd12) ? 4'd0 : min_q;

		grp_h = twelfths(hour_mod);
		grp_m = twelfths(min_grp);

		grp_d = '0;
		case (min_rem[2:0])
			3'd1: begin
				grp_d.code[0] = SEG_SHORT_PULSE;
				grp_d.len     = 3'd1;
			end
			3'd2: begin
				grp_d.code[0] = SEG_SHORT_PULSE;
				grp_d.code[1] = SEG_SHORT_GAP;
				grp_d.code[2] = SEG_SHORT_PULSE;
				grp_d.len     = 3'd3;
			end
			3'd3: begin
				grp_d.code[0] = SEG_LONG_PULSE;
				grp_d.len     = 3'd1;
			end
			3'd4: begin
				grp_d.code[0] = SEG_LONG_PULSE;
				grp_d.code[1] = SEG_SHORT_GAP;
				grp_d.code[2] = SEG_SHORT_PULSE;
				grp_d.len     = 3'd3;
			end
			default: grp_d.len = 3'd0;
		endcase

		off_m = 5'd2 + 5'(grp_h.len);
		off_d = off_m + 5'(grp_m.len);

		pat_next = '0;
		pat_next.count = (minute == 6'd0) ? off_m : 5'(off_d + 5'(grp_d.len));
		rel = '0;
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			if (k == 0) begin
				pat_next.code[k] = SEG_EMPTY;
			end else if (k == 1) begin
				pat_next.code[k] = SEG_SHORT_GAP;
			end else if (SEG_IDX_W'(k) < off_m) begin
				rel = SEG_IDX_W'(k) - 5'd2;
				pat_next.code[k] = grp_h.code[rel[2:0]];
			end else if (SEG_IDX_W'(k) < off_d) begin
				rel = SEG_IDX_W'(k) - off_m;
				pat_next.code[k] = grp_m.code[rel[2:0]];
			end else begin
				rel = SEG_IDX_W'(k) - off_d;
				pat_next.code[k] = grp_d.code[rel[2:0]];
			end
		end
	end

	assign in_ready  = !valid_s1 || pat_ready;
	assign in_acc    = in_valid && in_ready;
	assign pat_valid = valid_s1;
	assign pat       = pat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (pat_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pat_s1 <= pat_next;
		end
	end

endmodule

### hw/rtl/thp_queue.sv
// ----------------------------------------------------------------------------
// Haptic time encoder pattern queue
// Short FIFO of pattern words between the front end and the sequencer.
// ----------------------------------------------------------------------------
module thp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  thp_pkg::pattern_t push_pat,
	output logic              pop_valid,
	input  logic              pop,
	output thp_pkg::pattern_t head_pat
);
	import thp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pattern_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign head_pat   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_pat;
		end
	end

endmodule

### hw/rtl/thp_back.sv
// ----------------------------------------------------------------------------
// Haptic time encoder segment sequencer
// Walks the head pattern one segment a cycle, when not stalled, to the output.
// ----------------------------------------------------------------------------
module thp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  thp_pkg::pattern_t head_pat,
	output logic              pop,
	input  thp_pkg::timing_t  timing,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       duration_ms,
	output logic              motor_on,
	output logic [4:0]        segment_index,
	output logic              last_segment
);
	import thp_pkg::*;

	seg_idx_t  idx_q;
	logic      out_valid_q;
	ms_t       duration_q;
	logic      motor_on_q;
	seg_idx_t  index_q;
	logic      last_q;

	logic      load;
	logic      is_last;
	seg_code_t code;

	assign load    = head_valid && (!out_valid_q || out_ready);
	assign code    = head_pat.code[idx_q];
	assign is_last = (idx_q == SEG_IDX_W'(head_pat.count - 1'b1));
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// advance within the pattern, wrap on its last segment
			if (load) begin
				idx_q <= is_last ? '0 : SEG_IDX_W'(idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			duration_q <= seg_ms(code, timing);
			motor_on_q <= ~idx_q[0];
			index_q    <= idx_q;
			last_q     <= is_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign duration_ms   = duration_q;
	assign motor_on      = motor_on_q;
	assign segment_index = index_q;
	assign last_segment  = last_q;

endmodule

### hw/rtl/time_to_haptic_pattern_encoder.sv
// ----------------------------------------------------------------------------
// Haptic time encoder
// Turns hour and minute into the on/off segment list for a vibration motor.
// ----------------------------------------------------------------------------
//
//   port group   direction  handshake            carries
//   cfg (APB)    in/out     psel/penable/pready  four 16-bit timing registers
//   in           in         in_valid/in_ready    hour, minute
//   out          out        out_valid/out_ready  duration_ms, motor_on,
//                                                segment_index, last_segment
//
// A word's first segment reaches the output through the front register, the
// queue and the output register. The sequencer emits one segment a cycle
// while the output is not stalled; a pattern holds it for its 6 to 17
// segments.
// The front end and a two-entry queue keep taking words while it runs.
// Reset loads the timing registers with 50, 200, 400 and 1000 ms and empties
// every stage. A stalled output holds its word and backs up the queue.
module time_to_haptic_pattern_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] duration_ms,
	output logic        motor_on,
	output logic [4:0]  segment_index,
	output logic        last_segment
);
	import thp_pkg::*;

	timing_t  timing_q;
	reg_idx_t reg_sel;
	logic     cfg_wr;

	pattern_t front_pat;
	logic     front_valid;
	logic     queue_ready;
	pattern_t head_pat;
	logic     head_valid;
	logic     pop;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.short_pulse <= SHORT_PULSE_RST;
			timing_q.long_pulse  <= LONG_PULSE_RST;
			timing_q.short_gap   <= SHORT_GAP_RST;
			timing_q.long_gap    <= LONG_GAP_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_SHORT_PULSE: timing_q.short_pulse <= pwdata[15:0];
				REG_LONG_PULSE:  timing_q.long_pulse  <= pwdata[15:0];
				REG_SHORT_GAP:   timing_q.short_gap   <= pwdata[15:0];
				REG_LONG_GAP:    timing_q.long_gap    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SHORT_PULSE: prdata = {16'h0000, timing_q.short_pulse};
			REG_LONG_PULSE:  prdata = {16'h0000, timing_q.long_pulse};
			REG_SHORT_GAP:   prdata = {16'h0000, timing_q.short_gap};
			REG_LONG_GAP:    prdata = {16'h0000, timing_q.long_gap};
			default:         prdata = '0;
		endcase
	end

	thp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.hour      (hour),
		.minute    (minute),
		.pat_valid (front_valid),
		.pat_ready (queue_ready),
		.pat       (front_pat)
	);

	thp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (queue_ready),
		.push_pat   (front_pat),
		.pop_valid  (head_valid),
		.pop        (pop),
		.head_pat   (head_pat)
	);

	thp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_pat      (head_pat),
		.pop           (pop),
		.timing        (timing_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.duration_ms   (duration_ms),
		.motor_on      (motor_on),
		.segment_index (segment_index),
		.last_segment  (last_segment)
	);

endmodule

### hw/rtl/thp_checker.sv
// ----------------------------------------------------------------------------
// Haptic time encoder checker
// Port-level properties of the segment stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "time_to_haptic_pattern_encoder_defines.svh"

module thp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] duration_ms,
	input logic        motor_on,
	input logic [4:0]  segment_index,
	input logic        last_segment
);

	logic in_stall;
	logic out_stall;
	logic out_mid;

	assign in_stall  = in_valid && !in_ready;
	assign out_stall = out_valid && !out_ready;
	assign out_mid   = out_valid && out_ready && !last_segment;

	// a waiting input word stays put
	`THP_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(hour) && $stable(minute), "input word changed while waiting")

	// a stalled word stays put
	`THP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(duration_ms) && $stable(segment_index) && $stable(last_segment), "output word changed while stalled")

	// every pattern opens with an empty on segment
	`THP_ASSERT_NOW(a_open_empty, out_valid && segment_index == 5'd0, duration_ms == 16'd0 && motor_on && !last_segment, "pattern does not open with an empty pulse")

	// on and off alternate by position
	`THP_ASSERT_NOW(a_alternate, out_valid, motor_on == !segment_index[0], "motor state does not follow segment position")

	// within a pattern the next segment follows in the very next cycle
	`THP_ASSERT_NEXT(a_no_gap, out_mid, out_valid && segment_index == $past(segment_index) + 5'd1, "segment missing or out of order inside a pattern")

endmodule

bind time_to_haptic_pattern_encoder thp_checker u_thp_checker (.*);
